FILE: rtl/core/utat_pkg.sv
// ----------------------------------------------------------------------------
// utat_pkg
// Types, constants and the sequence decode function of the UTF-8 to ASCII
// transliterator.
// ----------------------------------------------------------------------------
package utat_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaxRes   = 3;

  // register map, byte addresses 4*index
  localparam logic [CfgAddrW-1:0] AddrUnknown = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrDegree  = 3'd4;

  localparam logic [7:0] UnknownReset = 8'd63;
  localparam logic [7:0] DegreeReset  = 8'd127;

  localparam logic [7:0] LeadTwo    = 8'hC2;
  localparam logic [7:0] LeadThree  = 8'hE2;
  localparam logic [7:0] LeadFourMk = 8'hF8;
  localparam logic [7:0] LeadFour   = 8'hF0;
  localparam logic [7:0] ContDegree = 8'hB0;
  localparam logic [7:0] ContNbsp   = 8'hA0;
  localparam logic [7:0] ContPunct  = 8'h80;
  localparam logic [7:0] ContMisc   = 8'h9A;
  localparam logic [7:0] ContWarn   = 8'hA0;

  localparam logic [7:0] GlyphSpace = 8'h20;
  localparam logic [7:0] GlyphDash  = 8'h2D;
  localparam logic [7:0] GlyphApos  = 8'h27;
  localparam logic [7:0] GlyphQuote = 8'h22;
  localparam logic [7:0] GlyphDot   = 8'h2E;
  localparam logic [7:0] GlyphBang  = 8'h21;

  typedef struct packed {
    logic [7:0] unknown_code;
    logic [7:0] degree_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [2:0] len;
  } dec_t;

  // results of one input byte, glyph[0] is delivered first
  typedef struct packed {
    logic [1:0]             cnt;
    logic [MaxRes-1:0][7:0] glyph;
  } res_t;

  function automatic logic [2:0] seq_len(logic [7:0] c);
    logic [2:0] l;
    l = 3'd1;
    if (!c[7]) begin
      l = 3'd1;
    end else if (c == LeadTwo) begin
      l = 3'd2;
    end else if (c == LeadThree) begin
      l = 3'd3;
    end else if ((c & LeadFourMk) == LeadFour) begin
      l = 3'd4;
    end
    return l;
  endfunction

  // decode one sequence starting at b0 with avail bytes left
  function automatic dec_t decode(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [2:0] avail, cfg_t cfg);
    dec_t       r;
    logic [2:0] need;
    need    = seq_len(b0);
    r.glyph = cfg.unknown_code;
    r.len   = 3'd1;
    if (!b0[7]) begin
      r.glyph = b0;
    end else if (need == 3'd1 || avail < need) begin
      r.len = 3'd1;
    end else if (need == 3'd2) begin
      r.len = 3'd2;
      if (b1 == ContDegree) begin
        r.glyph = cfg.degree_code;
      end else if (b1 == ContNbsp) begin
        r.glyph = GlyphSpace;
      end
    end else if (need == 3'd3) begin
      r.len = 3'd3;
      if (b1 == ContPunct) begin
        if (b2 inside {8'h93, 8'h94, 8'h95}) begin
          r.glyph = GlyphDash;
        end else if (b2 inside {8'h98, 8'h99, 8'hA2}) begin
          r.glyph = GlyphApos;
        end else if (b2 inside {8'h9C, 8'h9D}) begin
          r.glyph = GlyphQuote;
        end else if (b2 == 8'hA6) begin
          r.glyph = GlyphDot;
        end
      end else if (b1 == ContMisc && b2 == ContWarn) begin
        r.glyph = GlyphBang;
      end
    end else begin
      r.len = 3'd4;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/utat_in_if.sv
// ----------------------------------------------------------------------------
// utat_in_if
// Byte input channel: valid/ready with the raw byte and end-of-buffer flag.
// ----------------------------------------------------------------------------
interface utat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

FILE: rtl/core/utat_out_if.sv
// ----------------------------------------------------------------------------
// utat_out_if
// Glyph output channel: valid/ready with the display character and run flag.
// ----------------------------------------------------------------------------
interface utat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic       run_end;

  modport source (output valid, output glyph, output run_end, input ready);
  modport sink   (input valid, input glyph, input run_end, output ready);
endinterface

FILE: rtl/core/utat_cfg.sv
// ----------------------------------------------------------------------------
// utat_cfg
// APB register file: unknown code and degree code.
// ----------------------------------------------------------------------------
module utat_cfg
  import utat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [7:0] unknown_q, unknown_d;
  logic [7:0] degree_q, degree_d;
  logic       wr_en;
  logic       sel_degree;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite && pready;
  assign sel_degree = paddr[2];

  always_comb begin
    unknown_d = unknown_q;
    degree_d  = degree_q;
    if (wr_en) begin
      if (sel_degree) begin
        degree_d = pwdata[7:0];
      end else begin
        unknown_d = pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_q <= UnknownReset;
      degree_q  <= DegreeReset;
    end else begin
      unknown_q <= unknown_d;
      degree_q  <= degree_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_degree) begin
      prdata[7:0] = degree_q;
    end else begin
      prdata[7:0] = unknown_q;
    end
  end

  assign cfg_o.unknown_code = unknown_q;
  assign cfg_o.degree_code  = degree_q;

endmodule

FILE: rtl/core/utat_seq.sv
// ----------------------------------------------------------------------------
// utat_seq
// Pending sequence store and single-pass decode of one input byte into
// zero to three glyphs.
// ----------------------------------------------------------------------------
module utat_seq
  import utat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       xfer_i,
  input  logic [7:0] in_byte_i,
  input  logic       buffer_end_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [2:0][7:0] buf_q;
  logic [1:0]      fill_q, fill_d;
  logic [3:0][7:0] arr;
  logic [2:0]      n;
  logic [2:0]      p2;
  logic            complete;
  dec_t            d0, d1, d2;

  // lay the new byte behind the pending ones
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      arr[i] = (fill_q == i[1:0]) ? in_byte_i : buf_q[i];
    end
    arr[3] = in_byte_i;
  end

  assign n        = {1'b0, fill_q} + 3'd1;
  assign complete = n >= seq_len(arr[0]);

  // a partial flush only ever restarts at offset one, then offset two
  assign d0 = decode(arr[0], arr[1], arr[2], n, cfg_i);
  assign d1 = decode(arr[1], arr[2], arr[3], n - 3'd1, cfg_i);
  assign d2 = decode(arr[2], arr[3], 8'h00, n - 3'd2, cfg_i);
  assign p2 = 3'd1 + d1.len;

  always_comb begin
    res_o.cnt   = 2'd0;
    res_o.glyph = {d2.glyph, d1.glyph, d0.glyph};
    fill_d      = fill_q;
    if (buffer_end_i) begin
      fill_d    = 2'd0;
      res_o.cnt = 2'd1;
      if (d0.len < n) begin
        res_o.cnt = 2'd2;
        if (p2 < n) begin
          res_o.cnt = 2'd3;
        end
      end
    end else if (complete) begin
      fill_d    = 2'd0;
      res_o.cnt = 2'd1;
    end else begin
      fill_d = n[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else if (xfer_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_i && !buffer_end_i && !complete) begin
      buf_q[fill_q] <= in_byte_i;
    end
  end

`ifndef NO_ASSERTIONS
  // only a four-byte lead can leave three bytes pending
  a_fill3_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == 2'd3 |-> (buf_q[0] & LeadFourMk) == LeadFour)
    else $error("three bytes pending without a four-byte lead");
`endif

endmodule

FILE: rtl/core/utat_outq.sv
// ----------------------------------------------------------------------------
// utat_outq
// Result register: holds the glyphs of one input byte and delivers them one
// transfer per cycle while the output is ready.
// ----------------------------------------------------------------------------
module utat_outq
  import utat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  res_t              res_i,
  utat_out_if.source        out_o
);

  logic [MaxRes-1:0][7:0] glyph_q;
  logic [1:0]             cnt_q;
  logic                   take;
  logic                   load;

  assign take       = out_o.valid && out_o.ready;
  assign in_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= res_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      glyph_q <= res_i.glyph;
    end else if (take) begin
      glyph_q[0] <= glyph_q[1];
      glyph_q[1] <= glyph_q[2];
    end
  end

  assign out_o.valid   = cnt_q != 2'd0;
  assign out_o.glyph   = glyph_q[0];
  assign out_o.run_end = cnt_q == 2'd1;

`ifndef NO_ASSERTIONS
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && take)))
    else $error("result register overwritten with glyphs pending");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !load) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("pending count lost track of a transfer");
  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cnt_q == $past(res_i.cnt))
    else $error("result count not loaded");
`endif

endmodule

FILE: rtl/core/utf8_to_ascii_transliterator.sv
// Latency: a glyph is offered the cycle after the transfer of the byte that
// completes its sequence; bytes held in a pending sequence give no glyph.
// Throughput: one byte per cycle while each byte yields at most one glyph and
// the output is ready; a buffer-end flush yielding more than one glyph holds
// input while the single result register drains one glyph per output transfer.
// Reset: asynchronous; clears pending count and result count, codes 63/127.
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Top level: APB registers, sequence decode and result register.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator
  import utat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  utat_in_if.sink             in_i,
  utat_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  res_t res;
  logic in_ready;
  logic in_xfer;

  assign in_i.ready = in_ready;
  assign in_xfer    = in_i.valid && in_ready;

  utat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  utat_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (in_xfer),
    .in_byte_i    (in_i.in_byte),
    .buffer_end_i (in_i.buffer_end),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  utat_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .res_i      (res),
    .out_o      (out_o)
  );

endmodule

FILE: verif/tb_utf8_to_ascii_transliterator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_ascii_transliterator
// Self-checking bench: a directed byte table and then random UTF-8 streams, in
// phases with different unknown/degree codes. Every glyph transfer is compared
// with the glyph expected for the bytes taken in so far (typed or predicted).
// ----------------------------------------------------------------------------
module tb_utf8_to_ascii_transliterator;
  import utat_pkg::*;

  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned PhaseItems  = 40;
  localparam int unsigned NumPhases   = 5;

  typedef struct packed {
    logic [7:0] glyph;
    logic       run_end;
  } glyph_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [2:0] used;
  } span_t;

  // directed row: typed = expected glyphs written in the row, else predicted
  typedef struct packed {
    logic [7:0]      in_byte;
    logic            buffer_end;
    logic            typed;
    logic [1:0]      cnt;
    logic [2:0][7:0] gl;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  utat_in_if  in_if ();
  utat_out_if out_if ();

  utf8_to_ascii_transliterator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [7:0]      cfg_unknown;
  logic [7:0]      cfg_degree;
  logic [2:0][7:0] pend_bytes;
  int              pend_cnt;

  glyph_t glyph_q[$];
  row_t   dir_q[$];
  int     err_cnt;
  int     items_in_phase;
  bit     tx_idle;
  bit     rx_idle;
  bit     hold_req;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  function automatic logic [2:0] lead_span(logic [7:0] c);
    logic [2:0] l;
    l = 3'd1;
    if (c == LeadTwo) begin
      l = 3'd2;
    end else if (c == LeadThree) begin
      l = 3'd3;
    end else if ((c & LeadFourMk) == LeadFour) begin
      l = 3'd4;
    end
    return l;
  endfunction

  function automatic span_t decode_at(logic [5:0][7:0] arr, int pos, int avail);
    span_t      s;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [2:0] need;
    c0      = arr[pos];
    c1      = arr[pos+1];
    c2      = arr[pos+2];
    need    = lead_span(c0);
    s.glyph = cfg_unknown;
    s.used  = 3'd1;
    if (!c0[7]) begin
      s.glyph = c0;
    end else if (need == 3'd1 || avail < int'(need)) begin
      s.used = 3'd1;
    end else if (need == 3'd2) begin
      s.used = 3'd2;
      if (c1 == ContDegree) begin
        s.glyph = cfg_degree;
      end else if (c1 == ContNbsp) begin
        s.glyph = GlyphSpace;
      end
    end else if (need == 3'd3) begin
      s.used = 3'd3;
      if (c1 == ContPunct) begin
        case (c2)
          8'h93, 8'h94, 8'h95: s.glyph = GlyphDash;
          8'h98, 8'h99, 8'hA2: s.glyph = GlyphApos;
          8'h9C, 8'h9D:        s.glyph = GlyphQuote;
          8'hA6:               s.glyph = GlyphDot;
          default: ;
        endcase
      end else if (c1 == ContMisc && c2 == ContWarn) begin
        s.glyph = GlyphBang;
      end
    end else begin
      s.used = 3'd4;
    end
    return s;
  endfunction

  // glyphs caused by one byte; holds partial sequences in pend_bytes
  task automatic xlate_byte(input logic [7:0] b, input logic e, output int cnt,
                            output logic [2:0][7:0] gl);
    logic [5:0][7:0] arr;
    int              n;
    int              pos;
    int              i;
    span_t           s;
    arr = '0;
    gl  = '0;
    cnt = 0;
    for (i = 0; i < pend_cnt; i++) arr[i] = pend_bytes[i];
    arr[pend_cnt] = b;
    n = pend_cnt + 1;
    if (e) begin
      // flush: an unfinished lead gives the unknown code, the rest is redone
      pos = 0;
      while (pos < n && cnt < 3) begin
        s       = decode_at(arr, pos, n - pos);
        gl[cnt] = s.glyph;
        cnt++;
        pos += s.used;
      end
      pend_cnt = 0;
    end else if (n >= int'(lead_span(arr[0]))) begin
      s        = decode_at(arr, 0, n);
      gl[0]    = s.glyph;
      cnt      = 1;
      pend_cnt = 0;
    end else begin
      for (i = 0; i < n; i++) pend_bytes[i] = arr[i];
      pend_cnt = n;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic row_t mk_row(logic [7:0] b, logic e, logic typed, logic [1:0] cnt,
                                  logic [7:0] g0, logic [7:0] g1, logic [7:0] g2);
    row_t r;
    r.in_byte    = b;
    r.buffer_end = e;
    r.typed      = typed;
    r.cnt        = cnt;
    r.gl         = {g2, g1, g0};
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic e, input logic typed,
                           input int tcnt, input logic [2:0][7:0] tgl);
    int              cnt;
    int              k;
    int              g;
    logic [2:0][7:0] gl;
    glyph_t          x;
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.buffer_end <= e;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    xlate_byte(b, e, cnt, gl);
    if (typed) begin
      cnt = tcnt;
      gl  = tgl;
    end
    for (k = 0; k < cnt; k++) begin
      x.glyph   = gl[k];
      x.run_end = (k == cnt - 1);
      glyph_q.push_back(x);
    end
    items_in_phase++;
    g = tx_idle ? pick_gap() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // one UTF-8 sequence with random content, mostly well formed
  task automatic send_token();
    logic [7:0] seq[$];
    logic [7:0] tails[10];
    int         r;
    int         k;
    int         cut;
    logic       trunc;
    tails = '{8'h93, 8'h94, 8'h95, 8'h98, 8'h99, 8'h9C, 8'h9D, 8'hA2, 8'hA6, 8'h00};
    trunc = 1'b0;
    r     = $urandom_range(0, 99);
    if (r < 35) begin
      seq.push_back(8'($urandom_range(0, 127)));
    end else if (r < 50) begin
      seq.push_back(LeadTwo);
      k = $urandom_range(0, 2);
      seq.push_back(k == 0 ? ContDegree : k == 1 ? ContNbsp : 8'($urandom));
    end else if (r < 75) begin
      seq.push_back(LeadThree);
      k = $urandom_range(0, 9);
      if (k < 6) begin
        seq.push_back(ContPunct);
        k = $urandom_range(0, 9);
        seq.push_back(k == 9 ? 8'($urandom) : tails[k]);
      end else if (k < 8) begin
        seq.push_back(ContMisc);
        seq.push_back($urandom_range(0, 1) ? ContWarn : 8'($urandom));
      end else begin
        seq.push_back(8'($urandom));
        seq.push_back(8'($urandom));
      end
    end else if (r < 85) begin
      seq.push_back(LeadFour | 8'($urandom_range(0, 7)));
      for (k = 0; k < 3; k++) seq.push_back(8'($urandom));
    end else if (r < 93) begin
      seq.push_back(8'($urandom_range(128, 255)));
    end else begin
      // sequence cut short by the end of the buffer
      k = $urandom_range(0, 2);
      seq.push_back(k == 0 ? LeadTwo : k == 1 ? LeadThree : LeadFour | 8'($urandom_range(0, 7)));
      cut = (k == 0) ? 0 : $urandom_range(0, k);
      for (r = 0; r < cut; r++) seq.push_back(8'($urandom));
      trunc = 1'b1;
    end
    for (k = 0; k < seq.size(); k++) begin
      push_byte(seq[k], (trunc && k == seq.size() - 1) || ($urandom_range(0, 15) == 0),
                1'b0, 0, '0);
    end
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] a, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= CfgDataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == AddrUnknown) begin
      cfg_unknown = v;
    end else begin
      cfg_degree = v;
    end
    @(posedge clk_i);
  endtask

  // wait for every glyph, then let the result register go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // glyph checker
  always @(posedge clk_i) begin
    glyph_t x;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (glyph_q.size() == 0) begin
        $display("%0t: unexpected glyph %02h run_end %0b", $time, out_if.glyph,
                 out_if.run_end);
        err_cnt++;
      end else begin
        x = glyph_q.pop_front();
        if (out_if.glyph !== x.glyph) begin
          $display("%0t: glyph mismatch, expected %02h actual %02h", $time, x.glyph,
                   out_if.glyph);
          err_cnt++;
        end
        if (out_if.run_end !== x.run_end) begin
          $display("%0t: run_end mismatch, expected %0b actual %0b", $time, x.run_end,
                   out_if.run_end);
          err_cnt++;
        end
      end
    end
  end

  // glyph receiver
  initial begin
    int g;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!rx_idle) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        g = pick_gap();
        if (g > 0) out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_utf8_to_ascii_transliterator failed");
    $finish;
  end

  initial begin
    logic [7:0] ph_unk[NumPhases];
    logic [7:0] ph_deg[NumPhases];
    int         ph;
    int         i;
    bit         paused;
    row_t       r;

    err_cnt          = 0;
    items_in_phase   = 0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_req         = 1'b0;
    paused           = 1'b0;
    cfg_unknown      = UnknownReset;
    cfg_degree       = DegreeReset;
    pend_bytes       = '0;
    pend_cnt         = 0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= 8'h00;
    in_if.buffer_end <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;

    // directed table, run with the reset codes
    dir_q.push_back(mk_row(8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h7F, 1'b0, 1'b1, 2'd1, 8'h7F, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'hFF, 1'b1, 1'b1, 2'd1, UnknownReset, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h80, 1'b0, 1'b1, 2'd1, UnknownReset, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadTwo, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(ContDegree, 1'b0, 1'b1, 2'd1, DegreeReset, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadTwo, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(ContNbsp, 1'b0, 1'b1, 2'd1, GlyphSpace, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadThree, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(ContPunct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h93, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadThree, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(ContMisc, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(ContWarn, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadFour, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h9F, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h98, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h80, 1'b0, 1'b1, 2'd1, UnknownReset, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'hF8, 1'b0, 1'b1, 2'd1, UnknownReset, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadThree, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h41, 1'b1, 1'b1, 2'd2, UnknownReset, 8'h41, 8'h00));
    dir_q.push_back(mk_row(8'hF7, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(LeadThree, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00));
    dir_q.push_back(mk_row(8'h41, 1'b1, 1'b1, 2'd3, UnknownReset, UnknownReset, 8'h41));
    dir_q.push_back(mk_row(LeadTwo, 1'b1, 1'b1, 2'd1, UnknownReset, 8'h00, 8'h00));

    ph_unk = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), UnknownReset};
    ph_deg = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), DegreeReset};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < dir_q.size(); i++) begin
      r = dir_q[i];
      push_byte(r.in_byte, r.buffer_end, r.typed, int'(r.cnt), r.gl);
    end
    settle();

    for (ph = 0; ph < NumPhases; ph++) begin
      cfg_write(AddrUnknown, ph_unk[ph]);
      cfg_write(AddrDegree, ph_deg[ph]);
      tx_idle        = (ph != 3);
      rx_idle        = (ph != 3);
      hold_req       = (ph == 2);
      items_in_phase = 0;
      while (items_in_phase < PhaseItems) begin
        send_token();
        if (ph == 1 && !paused && items_in_phase >= PhaseItems / 2) begin
          in_if.valid <= 1'b0;
          while (glyph_q.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
          paused = 1'b1;
        end
      end
      // close the buffer so nothing stays pending across a code change
      push_byte(8'($urandom), 1'b1, 1'b0, 0, '0);
      settle();
    end

    if (err_cnt == 0) begin
      $display("tb_utf8_to_ascii_transliterator passed");
    end else begin
      $display("tb_utf8_to_ascii_transliterator failed");
    end
    $finish;
  end

endmodule
